>>> rtl/core/abff_pkg.sv
// Shared types and constants for the allocation bitmap find-first block.
// No dependencies; imported by every module of the block except abff_ram.
package abff_pkg;

    localparam int WORD_BITS_DEF = 64;
    localparam int MAX_BITS_DEF  = 4096;

    localparam int CFG_W   = 13;
    localparam int OP_W    = 3;
    localparam int IDX_W   = 12;
    localparam int POS_W   = 12;
    localparam int CFG_RESET = 4096;

    typedef enum logic [OP_W-1:0] {
        OP_SET         = 3'd0,
        OP_CLEAR       = 3'd1,
        OP_TEST        = 3'd2,
        OP_FIRST_SET   = 3'd3,
        OP_FIRST_CLEAR = 3'd4,
        OP_ALL_CLEAR   = 3'd5,
        OP_ALL_SET     = 3'd6,
        OP_FILL        = 3'd7
    } op_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // Update of the per-word summary flags, issued when a transaction retires
    typedef struct packed {
        logic write;     // one word rewritten
        logic fill;      // whole map filled
        logic value;     // fill value
        logic nonzero;   // rewritten word has a set bit
        logic all_ones;  // rewritten word has every bit set
    } sum_upd_t;

endpackage

>>> rtl/core/abff_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module abff_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // hold read data between reads
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/abff_summary.sv
// Per-word summary flags (written, nonzero, all ones) and the word-level search.
// Depends on abff_pkg.
module abff_summary #(
    parameter int NUM_WORDS = 64,
    parameter int WIDX_W    = 6,
    parameter int NW_W      = 7
) (
    input  logic               clk,
    input  logic               rst_n,
    input  abff_pkg::sum_upd_t upd,
    input  logic [WIDX_W-1:0]  upd_word,
    input  logic [NW_W-1:0]    nw,
    input  logic               find_clear,
    input  logic [WIDX_W-1:0]  query_word,
    output logic               found,
    output logic [WIDX_W-1:0]  found_word,
    output logic               all_clear,
    output logic               all_set,
    output logic               query_valid,
    output logic               default_value
);
    import abff_pkg::*;

    logic [NUM_WORDS-1:0] valid_reg;
    logic [NUM_WORDS-1:0] nonzero_reg;
    logic [NUM_WORDS-1:0] ones_reg;
    logic                 dflt_reg;

    logic [NUM_WORDS-1:0] in_use;
    logic [NUM_WORDS-1:0] has_set;
    logic [NUM_WORDS-1:0] has_clear;
    logic [NUM_WORDS-1:0] cand;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            nonzero_reg <= '0;
            ones_reg    <= '0;
            dflt_reg    <= 1'b0;
        end
        else if (upd.fill)
        begin
            // unwritten words read as the fill value from here on
            valid_reg   <= '0;
            nonzero_reg <= {NUM_WORDS{upd.value}};
            ones_reg    <= {NUM_WORDS{upd.value}};
            dflt_reg    <= upd.value;
        end
        else if (upd.write)
        begin
            valid_reg[upd_word]   <= 1'b1;
            nonzero_reg[upd_word] <= upd.nonzero;
            ones_reg[upd_word]    <= upd.all_ones;
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_WORDS; i++)
        begin
            in_use[i] = (NW_W'(i) < nw);
        end
        has_set   = nonzero_reg & in_use;
        has_clear = ~ones_reg & in_use;
        cand      = find_clear ? has_clear : has_set;
        found     = |cand;
        found_word = '0;
        for (int i = NUM_WORDS - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                found_word = WIDX_W'(i);
            end
        end
    end

    assign all_clear     = ~(|has_set);
    assign all_set       = ~(|has_clear);
    assign query_valid   = valid_reg[query_word];
    assign default_value = dflt_reg;

endmodule

>>> rtl/core/abff_ctrl.sv
// Transaction sequencer: decode, memory read-modify-write, result register, config.
// Depends on abff_pkg; drives abff_ram and abff_summary from the top level.
module abff_ctrl #(
    parameter int WORD_BITS = 64,
    parameter int NUM_WORDS = 64,
    parameter int WIDX_W    = 6,
    parameter int NW_W      = 7,
    parameter int MAX_BITS  = 4096
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [abff_pkg::OP_W-1:0]    op,
    input  logic [abff_pkg::IDX_W-1:0]   bit_index,
    input  logic                         fill_value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         flag,
    output logic [abff_pkg::POS_W-1:0]   position,
    output logic                         error,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [abff_pkg::CFG_W-1:0]   bits_in_use,
    output logic                         mem_we,
    output logic [WIDX_W-1:0]            mem_waddr,
    output logic [WORD_BITS-1:0]         mem_wdata,
    output logic                         mem_re,
    output logic [WIDX_W-1:0]            mem_raddr,
    input  logic [WORD_BITS-1:0]         mem_rdata,
    output abff_pkg::sum_upd_t           upd,
    output logic [WIDX_W-1:0]            upd_word,
    output logic [NW_W-1:0]              nw,
    output logic                         find_clear,
    output logic [WIDX_W-1:0]            query_word,
    input  logic                         found,
    input  logic [WIDX_W-1:0]            found_word,
    input  logic                         all_clear,
    input  logic                         all_set,
    input  logic                         query_valid,
    input  logic                         default_value
);
    import abff_pkg::*;

    localparam int BIT_W  = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam int LIM_W  = $clog2(MAX_BITS + 1);
    localparam int CMP_W  = (LIM_W > IDX_W) ? LIM_W : IDX_W;
    localparam int NWC_W  = (NW_W > CFG_W) ? NW_W : CFG_W;
    localparam int ABS_W0 = $clog2(MAX_BITS) + 1;
    localparam int ABS_W  = (ABS_W0 > POS_W) ? ABS_W0 : POS_W;
    localparam int NW_RESET_RAW = CFG_RESET / WORD_BITS;
    localparam int NW_RESET = (NW_RESET_RAW > NUM_WORDS) ? NUM_WORDS : NW_RESET_RAW;

    state_t              state_reg, state_next;
    op_t                 op_in;
    op_t                 op_reg, op_next;
    logic [WIDX_W-1:0]   word_reg, word_next;
    logic [BIT_W-1:0]    bit_reg, bit_next;
    logic                hit_reg, hit_next;
    logic                err_reg, err_next;
    logic                fill_reg, fill_next;
    logic [NW_W-1:0]     nw_reg;
    logic [NWC_W-1:0]    nw_raw;

    logic                out_valid_reg, out_valid_next;
    logic                flag_reg, flag_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic                error_reg, error_next;

    logic [CMP_W-1:0]    limit;
    logic                idx_ok;
    logic [WIDX_W-1:0]   idx_word;
    logic [BIT_W-1:0]    idx_bit;
    logic [WORD_BITS-1:0] word_eff;
    logic [WORD_BITS-1:0] bit_mask;
    logic [WORD_BITS-1:0] new_word;
    logic [WORD_BITS-1:0] search_word;
    logic [BIT_W-1:0]    lo;
    logic [ABS_W-1:0]    abs_pos;
    logic                accept;
    logic                retire;

    assign op_in      = op_t'(op);
    assign nw         = nw_reg;
    assign cfg_ready  = 1'b1;
    assign in_ready   = (state_reg == ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign find_clear = (op_in == OP_FIRST_CLEAR);
    assign query_word = word_reg;
    assign upd_word   = word_reg;
    assign mem_waddr  = word_reg;

    assign out_valid = out_valid_reg;
    assign flag      = flag_reg;
    assign position  = pos_reg;
    assign error     = error_reg;

    // words in use; the register below limits them to the store size
    assign nw_raw = NWC_W'(bits_in_use / WORD_BITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nw_reg <= NW_W'(NW_RESET);
        end
        else if (cfg_valid)
        begin
            nw_reg <= (nw_raw > NWC_W'(NUM_WORDS)) ? NW_W'(NUM_WORDS) : NW_W'(nw_raw);
        end
    end

    assign limit    = CMP_W'(nw_reg) * CMP_W'(WORD_BITS);
    assign idx_ok   = CMP_W'(bit_index) < limit;
    assign idx_word = WIDX_W'(bit_index / WORD_BITS);
    assign idx_bit  = BIT_W'(bit_index % WORD_BITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        word_reg  <= word_next;
        bit_reg   <= bit_next;
        hit_reg   <= hit_next;
        err_reg   <= err_next;
        fill_reg  <= fill_next;
        flag_reg  <= flag_next;
        pos_reg   <= pos_next;
        error_reg <= error_next;
    end

    // datapath on the word read back from memory
    always_comb
    begin
        word_eff    = query_valid ? mem_rdata : {WORD_BITS{default_value}};
        bit_mask    = {{(WORD_BITS - 1){1'b0}}, 1'b1} << bit_reg;
        new_word    = (op_reg == OP_SET) ? (word_eff | bit_mask) : (word_eff & ~bit_mask);
        search_word = (op_reg == OP_FIRST_CLEAR) ? ~word_eff : word_eff;
        lo = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (search_word[i])
            begin
                lo = BIT_W'(i);
            end
        end
        abs_pos = ABS_W'(word_reg) * ABS_W'(WORD_BITS) + ABS_W'(lo);
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        word_next      = word_reg;
        bit_next       = bit_reg;
        hit_next       = hit_reg;
        err_next       = err_reg;
        fill_next      = fill_reg;
        out_valid_next = out_valid_reg && !out_ready;
        flag_next      = flag_reg;
        pos_next       = pos_reg;
        error_next     = error_reg;
        mem_re         = 1'b0;
        mem_raddr      = idx_word;
        mem_we         = 1'b0;
        mem_wdata      = new_word;
        upd            = '0;
        retire         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next    = op_in;
                    fill_next  = fill_value;
                    bit_next   = idx_bit;
                    word_next  = idx_word;
                    err_next   = 1'b0;
                    hit_next   = 1'b0;
                    state_next = ST_EXEC;
                    case (op_in) inside
                        OP_SET, OP_CLEAR, OP_TEST:
                        begin
                            err_next = !idx_ok;
                            mem_re   = idx_ok;
                        end
                        OP_FIRST_SET, OP_FIRST_CLEAR:
                        begin
                            hit_next  = found;
                            word_next = found_word;
                            mem_raddr = found_word;
                            mem_re    = found;
                        end
                        OP_ALL_CLEAR:
                        begin
                            hit_next = all_clear;
                        end
                        OP_ALL_SET:
                        begin
                            hit_next = all_set;
                        end
                        default:
                        begin
                            hit_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_EXEC:
            begin
                // hold until the result register can take the transaction
                retire = !out_valid_reg || out_ready;
                if (retire)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    flag_next      = 1'b0;
                    pos_next       = '0;
                    error_next     = err_reg;
                    case (op_reg) inside
                        OP_SET, OP_CLEAR:
                        begin
                            mem_we        = !err_reg;
                            upd.write     = !err_reg;
                            upd.nonzero   = |new_word;
                            upd.all_ones  = &new_word;
                        end
                        OP_TEST:
                        begin
                            flag_next = !err_reg && word_eff[bit_reg];
                        end
                        OP_FIRST_SET, OP_FIRST_CLEAR:
                        begin
                            flag_next = hit_reg;
                            pos_next  = hit_reg ? abs_pos[POS_W-1:0] : '0;
                        end
                        OP_ALL_CLEAR, OP_ALL_SET:
                        begin
                            flag_next = hit_reg;
                        end
                        default:
                        begin
                            upd.fill  = 1'b1;
                            upd.value = fill_reg;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/allocation_bitmap_find_first_top.sv
// Top level of the allocation bitmap with find-first-set / find-first-clear.
// Depends on abff_pkg, abff_ram, abff_summary and abff_ctrl.
//
// Every transaction is accepted in ST_IDLE and retires from ST_EXEC into a
// registered result: the accept cycle decodes the request, checks the index
// against the words in use and starts at most one read of the bitmap RAM; in
// ST_EXEC the block works on the word read back, writes it back for set and
// clear, and loads the result register. Searches need only one read because
// per-word nonzero and all-ones flags in flip-flops pick the target word
// directly. The next request is taken while a result still waits in the
// output register; a new transaction retires only once that register is
// free. Fill takes effect through per-word written flags, so there is no
// clearing pass after reset. The configuration register may be written at
// any time the block is idle.
module allocation_bitmap_find_first_top #(
    parameter int WORD_BITS = abff_pkg::WORD_BITS_DEF,
    parameter int MAX_BITS  = abff_pkg::MAX_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [abff_pkg::OP_W-1:0]   op,
    input  logic [abff_pkg::IDX_W-1:0]  bit_index,
    input  logic                        fill_value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        flag,
    output logic [abff_pkg::POS_W-1:0]  position,
    output logic                        error,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [abff_pkg::CFG_W-1:0]  bits_in_use
);
    import abff_pkg::*;

    localparam int NUM_WORDS = MAX_BITS / WORD_BITS;
    localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int NW_W      = $clog2(NUM_WORDS + 1);

    logic                 mem_we;
    logic [WIDX_W-1:0]    mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [WIDX_W-1:0]    mem_raddr;
    logic [WORD_BITS-1:0] mem_rdata;
    sum_upd_t             upd;
    logic [WIDX_W-1:0]    upd_word;
    logic [NW_W-1:0]      nw;
    logic                 find_clear;
    logic [WIDX_W-1:0]    query_word;
    logic                 found;
    logic [WIDX_W-1:0]    found_word;
    logic                 all_clear;
    logic                 all_set;
    logic                 query_valid;
    logic                 default_value;

    abff_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS),
        .AW    (WIDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    abff_summary #(
        .NUM_WORDS (NUM_WORDS),
        .WIDX_W    (WIDX_W),
        .NW_W      (NW_W)
    ) u_summary (
        .clk           (clk),
        .rst_n         (rst_n),
        .upd           (upd),
        .upd_word      (upd_word),
        .nw            (nw),
        .find_clear    (find_clear),
        .query_word    (query_word),
        .found         (found),
        .found_word    (found_word),
        .all_clear     (all_clear),
        .all_set       (all_set),
        .query_valid   (query_valid),
        .default_value (default_value)
    );

    abff_ctrl #(
        .WORD_BITS (WORD_BITS),
        .NUM_WORDS (NUM_WORDS),
        .WIDX_W    (WIDX_W),
        .NW_W      (NW_W),
        .MAX_BITS  (MAX_BITS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .bit_index     (bit_index),
        .fill_value    (fill_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .flag          (flag),
        .position      (position),
        .error         (error),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .bits_in_use   (bits_in_use),
        .mem_we        (mem_we),
        .mem_waddr     (mem_waddr),
        .mem_wdata     (mem_wdata),
        .mem_re        (mem_re),
        .mem_raddr     (mem_raddr),
        .mem_rdata     (mem_rdata),
        .upd           (upd),
        .upd_word      (upd_word),
        .nw            (nw),
        .find_clear    (find_clear),
        .query_word    (query_word),
        .found         (found),
        .found_word    (found_word),
        .all_clear     (all_clear),
        .all_set       (all_set),
        .query_valid   (query_valid),
        .default_value (default_value)
    );

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for allocation_bitmap_find_first_top: sends bitmap requests and
// bits_in_use writes over valid/ready and checks every result against a local bitmap copy.
// Depends on abff_pkg and the block's RTL.
module testbench;
    import abff_pkg::*;

    localparam int WORD_BITS    = WORD_BITS_DEF;
    localparam int NUM_WORDS    = MAX_BITS_DEF / WORD_BITS;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_ITEMS  = 130;

    typedef struct {
        op_t              code;
        logic [IDX_W-1:0] idx;
        logic             fillv;
        bit               drain;   // hold until every pending result has come back
    } bitmap_req_t;

    typedef struct packed {
        logic             flag;
        logic [POS_W-1:0] position;
        logic             err;
    } bitmap_result_t;

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             in_valid    = 1'b0;
    logic             in_ready;
    logic [OP_W-1:0]  op          = '0;
    logic [IDX_W-1:0] bit_index   = '0;
    logic             fill_value  = 1'b0;
    logic             out_valid;
    logic             out_ready   = 1'b0;
    logic             flag;
    logic [POS_W-1:0] position;
    logic             error;
    logic             cfg_valid   = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] bits_in_use = CFG_W'(CFG_RESET);

    // Local copy of the bitmap and of the bits_in_use register
    logic [WORD_BITS-1:0] map_words [NUM_WORDS] = '{default: '0};
    logic [CFG_W-1:0]     span_cfg = CFG_W'(CFG_RESET);

    bitmap_req_t    pending[$];
    bitmap_result_t expected_results[$];
    bit             in_fire      = 1'b0;
    bit             calm         = 1'b0;
    int unsigned    in_idle_pct  = 0;
    int unsigned    out_idle_pct = 0;
    int unsigned    in_gap       = 0;
    int unsigned    out_gap      = 0;
    int unsigned    cycles       = 0;
    int unsigned    mismatches   = 0;

    allocation_bitmap_find_first_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .bit_index  (bit_index),
        .fill_value (fill_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .flag       (flag),
        .position   (position),
        .error      (error),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .bits_in_use(bits_in_use)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Bits covered by whole words in use, capped at the store size
    function automatic int unsigned span_limit();
        int unsigned nw;
        nw = span_cfg / WORD_BITS;
        if (nw > NUM_WORDS)
            nw = NUM_WORDS;
        return nw * WORD_BITS;
    endfunction

    function automatic bitmap_result_t bitmap_apply(op_t code, logic [IDX_W-1:0] idx,
                                                    logic fillv);
        bitmap_result_t       r;
        int unsigned          limit;
        int unsigned          wi;
        int                   lowest;
        logic [WORD_BITS-1:0] w;
        r     = '0;
        limit = span_limit();
        wi    = idx / WORD_BITS;
        case (code) inside
            OP_SET, OP_CLEAR, OP_TEST:
            begin
                if (idx >= limit)
                    r.err = 1'b1;
                else if (code == OP_SET)
                    map_words[wi][idx % WORD_BITS] = 1'b1;
                else if (code == OP_CLEAR)
                    map_words[wi][idx % WORD_BITS] = 1'b0;
                else
                    r.flag = map_words[wi][idx % WORD_BITS];
            end
            OP_FIRST_SET, OP_FIRST_CLEAR:
            begin
                for (int i = 0; i < limit / WORD_BITS && !r.flag; i++)
                begin
                    w = (code == OP_FIRST_CLEAR) ? ~map_words[i] : map_words[i];
                    if (w != '0)
                    begin
                        lowest = 0;
                        for (int b = WORD_BITS - 1; b >= 0; b--)
                            if (w[b])
                                lowest = b;
                        r.flag     = 1'b1;
                        r.position = POS_W'(i * WORD_BITS + lowest);
                    end
                end
            end
            OP_ALL_CLEAR, OP_ALL_SET:
            begin
                r.flag = 1'b1;
                for (int i = 0; i < limit / WORD_BITS; i++)
                    if ((code == OP_ALL_CLEAR && map_words[i] != '0) ||
                        (code == OP_ALL_SET && ~map_words[i] != '0))
                        r.flag = 1'b0;
            end
            default:
            begin
                // fill reaches every word, in use or not
                foreach (map_words[i])
                    map_words[i] = {WORD_BITS{fillv}};
            end
        endcase
        return r;
    endfunction

    function automatic bitmap_req_t random_request();
        bitmap_req_t q;
        int unsigned limit;
        int unsigned pick;
        int          boundary;
        limit = span_limit();
        pick  = $urandom_range(0, 99);
        if (pick < 24)
            q.code = OP_SET;
        else if (pick < 41)
            q.code = OP_CLEAR;
        else if (pick < 55)
            q.code = OP_TEST;
        else if (pick < 65)
            q.code = OP_FIRST_SET;
        else if (pick < 75)
            q.code = OP_FIRST_CLEAR;
        else if (pick < 83)
            q.code = OP_ALL_CLEAR;
        else if (pick < 91)
            q.code = OP_ALL_SET;
        else if (pick < 95)
            q.code = OP_FILL;
        else
            q.code = OP_SET;
        // Bias indexes toward the span, a low window and the span's upper edge
        pick = $urandom_range(0, 99);
        if (pick < 50 && limit > 0)
            q.idx = IDX_W'($urandom_range(0, limit - 1));
        else if (pick < 70)
            q.idx = IDX_W'($urandom_range(0, 127));
        else if (pick < 85)
        begin
            boundary = int'(limit) + int'($urandom_range(0, 7)) - 4;
            q.idx    = IDX_W'((boundary < 0) ? 0 : boundary);
        end
        else
            q.idx = IDX_W'($urandom);
        q.fillv = 1'($urandom_range(0, 1));
        q.drain = ($urandom_range(0, 99) == 0);
        return q;
    endfunction

    function automatic void queue_req(op_t code, int idx, logic fillv, bit drain = 1'b0);
        bitmap_req_t q;
        q.code  = code;
        q.idx   = IDX_W'(idx);
        q.fillv = fillv;
        q.drain = drain;
        pending.push_back(q);
    endfunction

    task automatic wait_idle();
        while (pending.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_span(logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_valid   <= 1'b1;
        bits_in_use <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        span_cfg = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Request driver
    always @(negedge clk)
    begin
        bitmap_req_t item;
        if (rst_n && (!in_valid || in_fire))
        begin
            if (in_gap != 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (pending.size() != 0 &&
                     !(pending[0].drain && expected_results.size() != 0))
            begin
                item = pending.pop_front();
                in_valid   <= 1'b1;
                op         <= item.code;
                bit_index  <= item.idx;
                fill_value <= item.fillv;
                if (!calm && $urandom_range(0, 99) < in_idle_pct)
                    in_gap = $urandom_range(1, 13);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result receiver: stall in bursts
    always @(negedge clk)
    begin
        if (out_gap != 0)
        begin
            out_gap--;
            out_ready <= 1'b0;
        end
        else if (rst_n && !calm && $urandom_range(0, 99) < out_idle_pct)
        begin
            out_gap = $urandom_range(0, 12);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Monitor: predict on request transactions, check on result transactions
    always @(posedge clk)
    begin
        bitmap_result_t want;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
        begin
            in_fire = rst_n && in_valid && in_ready;
            if (in_fire)
                expected_results.push_back(bitmap_apply(op_t'(op), bit_index, fill_value));
            if (rst_n && out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result transaction: flag %0d position %0d error %0d",
                           flag, position, error);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (flag !== want.flag)
                    begin
                        $error("flag: expected %0d, actual %0d", want.flag, flag);
                        mismatches++;
                    end
                    if (position !== want.position)
                    begin
                        $error("position: expected %0d, actual %0d", want.position, position);
                        mismatches++;
                    end
                    if (error !== want.err)
                    begin
                        $error("error: expected %0d, actual %0d", want.err, error);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial
    begin
        int unsigned spans[9];
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed pass on the reset span
        queue_req(OP_ALL_CLEAR, 0, 1'b0);
        queue_req(OP_ALL_SET, 4095, 1'b1);
        queue_req(OP_FIRST_SET, 0, 1'b0);
        queue_req(OP_FIRST_CLEAR, 0, 1'b0);
        queue_req(OP_SET, 0, 1'b0);
        queue_req(OP_SET, 4095, 1'b1);
        queue_req(OP_TEST, 4095, 1'b0);
        queue_req(OP_TEST, 1, 1'b0);
        queue_req(OP_FIRST_SET, 0, 1'b0, 1'b1);
        queue_req(OP_CLEAR, 0, 1'b0);
        queue_req(OP_FIRST_SET, 0, 1'b0);
        queue_req(OP_FIRST_CLEAR, 0, 1'b0);
        queue_req(OP_FILL, 0, 1'b1);
        queue_req(OP_ALL_SET, 0, 1'b0);
        queue_req(OP_FIRST_CLEAR, 0, 1'b0);
        queue_req(OP_CLEAR, 4095, 1'b0);
        queue_req(OP_FIRST_CLEAR, 0, 1'b0);
        queue_req(OP_ALL_SET, 0, 1'b0);
        queue_req(OP_FILL, 4095, 1'b0);
        queue_req(OP_ALL_CLEAR, 0, 1'b0);
        queue_req(OP_TEST, 4095, 1'b0);

        // Spans: smallest, register maximum, none, partial word, two words, random, one under full, full store
        spans = '{64, 8191, 0, 100, 128, 64 * $urandom_range(1, 63),
                  64 * $urandom_range(1, 63), 4095, 4096};
        foreach (spans[p])
        begin
            wait_idle();
            write_span(CFG_W'(spans[p]));
            if (p == $size(spans) - 1)
                calm = 1'b1;
            in_idle_pct  = 10 * $urandom_range(0, 5);
            out_idle_pct = 4 * $urandom_range(0, 4);
            repeat (PHASE_ITEMS)
                pending.push_back(random_request());
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/abff_pkg.sv
rtl/core/abff_ram.sv
rtl/core/abff_summary.sv
rtl/core/abff_ctrl.sv
rtl/core/allocation_bitmap_find_first_top.sv
tb/sv/testbench.sv
